[src/gas_sensor_adc_to_ppm_top_macros.svh]
// Assertion macros used by the port-level checker of the gas sensor converter.
`ifndef GAS_SENSOR_ADC_TO_PPM_TOP_MACROS_SVH
`define GAS_SENSOR_ADC_TO_PPM_TOP_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define GSPPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define GSPPM_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gsppm_pkg.sv]
// Types, constants and constant tables of the gas sensor converter.
`timescale 1ns / 1ps

package gsppm_pkg;

   localparam int FRAC_BITS = 20;
   localparam int NUM_W     = 56;
   localparam int DEN_W     = 28;
   localparam int STEP_W    = 6;
   localparam int ADC_PORT_W = 12;

   localparam logic [31:0] RS_SAT = 32'hFFFF_FFFF;

   // Slope 1/0.77 and offset 1.7*log2(10)/0.77, both in Q.20.
   localparam logic signed [21:0] EXP_SLOPE = 22'sd1361787;
   localparam int EXP_OFFSET = 7690390;
   // Offset plus the ten fraction bits of the Q22.10 output.
   localparam logic signed [47:0] Z_BIAS = 48'(EXP_OFFSET + (10 << FRAC_BITS));

   localparam logic [15:0] FULL_SCALE_RST = 16'd4095;
   localparam logic [15:0] GAIN_RST       = 16'd256;
   localparam logic [31:0] LOAD_RES_RST   = 32'd655360;
   localparam logic [31:0] BASELINE_RST   = 32'd65536;

   localparam logic [1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [1:0] CSR_GAIN       = 2'd1;
   localparam logic [1:0] CSR_LOAD_RES   = 2'd2;

   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_CAL     = 1'b1;
   localparam logic KIND_PPM    = 1'b0;
   localparam logic KIND_CAL    = 1'b1;

   typedef enum logic [12:0] {
      ST_IDLE = 13'h0001,
      ST_CAL  = 13'h0002,
      ST_RMUL = 13'h0004,
      ST_RCHK = 13'h0008,
      ST_DIV  = 13'h0010,
      ST_RSOK = 13'h0020,
      ST_LOGN = 13'h0040,
      ST_LOGS = 13'h0080,
      ST_ZMUL = 13'h0100,
      ST_ZCHK = 13'h0200,
      ST_EXP  = 13'h0400,
      ST_FIN  = 13'h0800,
      ST_DONE = 13'h1000
   } state_type;

   typedef enum logic [1:0] {
      DV_AVG = 2'd0,
      DV_RS  = 2'd1,
      DV_R0  = 2'd2
   } div_sel_type;

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      x = v;
      for (int i = 0; i < 32; i++) begin
         if (b > x) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry k holds 2^(2^-(k+1)) in Q30, each the root of the one before.
   function automatic logic [FRAC_BITS-1:0][31:0] exp_table();
      logic [63:0] t;
      logic [FRAC_BITS-1:0][31:0] tab;
      t = isqrt64(64'd1 << 61);
      for (int k = 0; k < FRAC_BITS; k++) begin
         tab[k] = t[31:0];
         t = isqrt64(t << 30);
      end
      return tab;
   endfunction

   localparam logic [FRAC_BITS-1:0][31:0] EXP_FACTOR = exp_table();

endpackage

[src/gas_sensor_adc_to_ppm_top.sv]
// Gas sensor converter: ADC sample to sensor resistance, baseline and ppm.
`timescale 1ns / 1ps
// A measure beat runs the 56-step divider, two log2 runs (up to 31 normalize shifts, then 20
// squarings) and 20 exponent steps; the exponent steps are skipped when the exponent clamps,
// and the log2 and exponent work when the reading is flagged. A calibration beat that ends
// no run only adds its sample; the last divides for the average, the resistance (unless it
// needs none) and the baseline. One beat is in work at a time; the next is taken the cycle
// after a result is written, even while it waits. Reset restores a 1.0 kilohm baseline.

module gas_sensor_adc_to_ppm_top #(
   parameter int ADC_BITS    = 12,
   parameter int CAL_SAMPLES = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [11:0] req_adc_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_gas_ppm,
   output logic [31:0] rsp_sensor_resistance,
   output logic [31:0] rsp_baseline_value,
   output logic        rsp_reading_invalid,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Only the low ADC_BITS bits of the sample count, up to the port width.
   localparam int ADC_W = (ADC_BITS < gsppm_pkg::ADC_PORT_W) ? ADC_BITS
                                                              : gsppm_pkg::ADC_PORT_W;
   localparam logic [11:0] ADC_MASK = 12'((64'd1 << ADC_W) - 1);
   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W = 12 + CNT_W;

   gsppm_pkg::state_type   st_ff, st_in;
   gsppm_pkg::div_sel_type dv_sel_ff, dv_sel_in;

   logic [15:0] fs_ff, fs_in;
   logic [15:0] gain_ff, gain_in;
   logic [31:0] rl_ff, rl_in;

   logic [31:0]      r0_ff, r0_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic        cmd_ff, cmd_in;
   logic [11:0] adc_ff, adc_in;
   logic [27:0] n_ff, n_in;
   logic [31:0] rs_ff, rs_in;
   logic [31:0] ppm_ff, ppm_in;
   logic        inv_ff, inv_in;

   logic [55:0] dv_num_ff, dv_num_in;
   logic [27:0] dv_den_ff, dv_den_in;
   logic [27:0] dv_rem_ff, dv_rem_in;
   logic [31:0] dv_q_ff, dv_q_in;
   logic        dv_ovf_ff, dv_ovf_in;
   logic [gsppm_pkg::STEP_W-1:0] step_ff, step_in;

   logic [31:0] lg_m_ff, lg_m_in;
   logic [4:0]  lg_p_ff, lg_p_in;
   logic [24:0] lg_r_ff, lg_r_in;
   logic        lg_sel_ff, lg_sel_in;
   logic [24:0] lr0_ff, lr0_in;

   logic signed [47:0] zp_ff, zp_in;
   logic [4:0]  ip_ff, ip_in;
   logic [19:0] fr_ff, fr_in;
   logic [31:0] em_ff, em_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_ppm_ff, rsp_ppm_in;
   logic [31:0] rsp_rs_ff, rsp_rs_in;
   logic [31:0] rsp_base_ff, rsp_base_in;
   logic        rsp_inv_ff, rsp_inv_in;

   // Datapath pieces that feed the sequencer.
   logic [11:0]        adc_masked;
   logic [27:0]        n_prod;
   logic [23:0]        d_val;
   logic [23:0]        d_minus_n;
   logic               n_ge_d;
   logic [55:0]        rl_prod;
   logic [28:0]        rem_sh;
   logic [28:0]        rem_sub;
   logic               rem_ge;
   logic [31:0]        q_next;
   logic               ovf_next;
   logic [63:0]        sq;
   logic [32:0]        sq_hi;
   logic [24:0]        lg_r_next;
   logic [63:0]        ep;
   logic signed [25:0] d_log;
   logic signed [47:0] z_val;
   logic               z_big;
   logic [63:0]        fin_sh;
   logic [CNT_W-1:0]   cnt_inc;
   logic [SUM_W-1:0]   sum_inc;

   assign adc_masked = req_adc_sample & ADC_MASK;
   assign n_prod     = adc_ff * gain_ff;
   assign d_val      = {fs_ff, 8'h00};
   assign d_minus_n  = d_val - n_ff[23:0];
   assign n_ge_d     = n_ff >= {4'h0, d_val};
   assign rl_prod    = rl_ff * d_minus_n;

   // One quotient bit per cycle of the restoring divider.
   assign rem_sh   = {dv_rem_ff, dv_num_ff[55]};
   assign rem_sub  = rem_sh - {1'b0, dv_den_ff};
   assign rem_ge   = rem_sh >= {1'b0, dv_den_ff};
   assign q_next   = {dv_q_ff[30:0], rem_ge};
   assign ovf_next = dv_ovf_ff | dv_q_ff[31];

   // One log2 fraction bit per squaring of the Q1.31 mantissa.
   assign sq        = lg_m_ff * lg_m_ff;
   assign sq_hi     = sq[63:31];
   assign lg_r_next = {lg_r_ff[23:0], sq_hi[32]};

   assign ep     = em_ff * gsppm_pkg::EXP_FACTOR[step_ff[4:0]];
   assign d_log  = $signed({1'b0, lr0_ff}) - $signed({1'b0, lg_r_ff});
   assign z_val  = gsppm_pkg::Z_BIAS + (zp_ff >>> gsppm_pkg::FRAC_BITS);
   assign z_big  = z_val[46:25] != '0;
   assign fin_sh = {32'h0, em_ff} << ip_ff;

   assign cnt_inc = cnt_ff + 1'b1;
   assign sum_inc = sum_ff + SUM_W'(adc_ff);

   always_comb begin
      st_in     = st_ff;
      dv_sel_in = dv_sel_ff;
      fs_in     = fs_ff;
      gain_in   = gain_ff;
      rl_in     = rl_ff;
      r0_in     = r0_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      adc_in    = adc_ff;
      n_in      = n_ff;
      rs_in     = rs_ff;
      ppm_in    = ppm_ff;
      inv_in    = inv_ff;
      dv_num_in = dv_num_ff;
      dv_den_in = dv_den_ff;
      dv_rem_in = dv_rem_ff;
      dv_q_in   = dv_q_ff;
      dv_ovf_in = dv_ovf_ff;
      step_in   = step_ff;
      lg_m_in   = lg_m_ff;
      lg_p_in   = lg_p_ff;
      lg_r_in   = lg_r_ff;
      lg_sel_in = lg_sel_ff;
      lr0_in    = lr0_ff;
      zp_in     = zp_ff;
      ip_in     = ip_ff;
      fr_in     = fr_ff;
      em_in     = em_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ppm_in   = rsp_ppm_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_inv_in   = rsp_inv_ff;

      if (csr_write) begin
         unique case (csr_index)
            gsppm_pkg::CSR_FULL_SCALE: fs_in   = csr_wdata[15:0];
            gsppm_pkg::CSR_GAIN:       gain_in = csr_wdata[15:0];
            gsppm_pkg::CSR_LOAD_RES:   rl_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (st_ff)
         gsppm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               adc_in = adc_masked;
               st_in  = (req_command == gsppm_pkg::CMD_CAL) ? gsppm_pkg::ST_CAL
                                                            : gsppm_pkg::ST_RMUL;
            end
         end
         gsppm_pkg::ST_CAL: begin
            if (cnt_inc < CNT_W'(CAL_SAMPLES)) begin
               sum_in = sum_inc;
               cnt_in = cnt_inc;
               st_in  = gsppm_pkg::ST_IDLE;
            end else begin
               // End of the run: average the floor samples.
               dv_num_in = 56'(sum_inc);
               dv_den_in = 28'(CAL_SAMPLES);
               dv_rem_in = '0;
               dv_q_in   = '0;
               dv_ovf_in = 1'b0;
               step_in   = '0;
               dv_sel_in = gsppm_pkg::DV_AVG;
               sum_in    = '0;
               cnt_in    = '0;
               st_in     = gsppm_pkg::ST_DIV;
            end
         end
         gsppm_pkg::ST_RMUL: begin
            n_in  = n_prod;
            st_in = gsppm_pkg::ST_RCHK;
         end
         gsppm_pkg::ST_RCHK: begin
            if (adc_ff == '0) begin
               rs_in = gsppm_pkg::RS_SAT;
               st_in = gsppm_pkg::ST_RSOK;
            end else if (n_ge_d) begin
               rs_in = '0;
               st_in = gsppm_pkg::ST_RSOK;
            end else begin
               dv_num_in = rl_prod;
               dv_den_in = n_ff;
               dv_rem_in = '0;
               dv_q_in   = '0;
               dv_ovf_in = 1'b0;
               step_in   = '0;
               dv_sel_in = gsppm_pkg::DV_RS;
               st_in     = gsppm_pkg::ST_DIV;
            end
         end
         gsppm_pkg::ST_DIV: begin
            dv_num_in = {dv_num_ff[54:0], 1'b0};
            dv_rem_in = rem_ge ? rem_sub[27:0] : rem_sh[27:0];
            dv_q_in   = q_next;
            dv_ovf_in = ovf_next;
            step_in   = step_ff + 1'b1;
            if (step_ff == gsppm_pkg::STEP_W'(gsppm_pkg::NUM_W - 1)) begin
               unique case (dv_sel_ff)
                  gsppm_pkg::DV_AVG: begin
                     adc_in = q_next[11:0];
                     st_in  = gsppm_pkg::ST_RMUL;
                  end
                  gsppm_pkg::DV_RS: begin
                     rs_in = ovf_next ? gsppm_pkg::RS_SAT : q_next;
                     st_in = gsppm_pkg::ST_RSOK;
                  end
                  gsppm_pkg::DV_R0: begin
                     r0_in  = q_next;
                     ppm_in = '0;
                     inv_in = 1'b0;
                     st_in  = gsppm_pkg::ST_DONE;
                  end
                  default: st_in = gsppm_pkg::ST_DONE;
               endcase
            end
         end
         gsppm_pkg::ST_RSOK: begin
            if (cmd_ff == gsppm_pkg::CMD_CAL) begin
               // New baseline is two thirds of the floor resistance.
               dv_num_in = 56'({rs_ff, 1'b0});
               dv_den_in = 28'd3;
               dv_rem_in = '0;
               dv_q_in   = '0;
               dv_ovf_in = 1'b0;
               step_in   = '0;
               dv_sel_in = gsppm_pkg::DV_R0;
               st_in     = gsppm_pkg::ST_DIV;
            end else if (rs_ff == '0 || adc_ff == '0 || r0_ff == '0) begin
               ppm_in = '0;
               inv_in = 1'b1;
               st_in  = gsppm_pkg::ST_DONE;
            end else begin
               lg_m_in   = r0_ff;
               lg_p_in   = 5'd31;
               lg_sel_in = 1'b0;
               st_in     = gsppm_pkg::ST_LOGN;
            end
         end
         gsppm_pkg::ST_LOGN: begin
            if (lg_p_ff != '0 && !lg_m_ff[31]) begin
               lg_m_in = {lg_m_ff[30:0], 1'b0};
               lg_p_in = lg_p_ff - 1'b1;
            end else begin
               lg_r_in = 25'(lg_p_ff);
               step_in = '0;
               st_in   = gsppm_pkg::ST_LOGS;
            end
         end
         gsppm_pkg::ST_LOGS: begin
            lg_m_in = sq_hi[32] ? sq_hi[32:1] : sq_hi[31:0];
            lg_r_in = lg_r_next;
            step_in = step_ff + 1'b1;
            if (step_ff == gsppm_pkg::STEP_W'(gsppm_pkg::FRAC_BITS - 1)) begin
               if (!lg_sel_ff) begin
                  lr0_in    = lg_r_next;
                  lg_m_in   = rs_ff;
                  lg_p_in   = 5'd31;
                  lg_sel_in = 1'b1;
                  st_in     = gsppm_pkg::ST_LOGN;
               end else begin
                  st_in = gsppm_pkg::ST_ZMUL;
               end
            end
         end
         gsppm_pkg::ST_ZMUL: begin
            zp_in = d_log * gsppm_pkg::EXP_SLOPE;
            st_in = gsppm_pkg::ST_ZCHK;
         end
         gsppm_pkg::ST_ZCHK: begin
            inv_in = 1'b0;
            if (z_val[47]) begin
               ppm_in = '0;
               st_in  = gsppm_pkg::ST_DONE;
            end else if (z_big) begin
               ppm_in = gsppm_pkg::RS_SAT;
               st_in  = gsppm_pkg::ST_DONE;
            end else begin
               ip_in   = z_val[24:20];
               fr_in   = z_val[19:0];
               em_in   = 32'h4000_0000;
               step_in = '0;
               st_in   = gsppm_pkg::ST_EXP;
            end
         end
         gsppm_pkg::ST_EXP: begin
            if (fr_ff[19]) begin
               em_in = ep[61:30];
            end
            fr_in   = {fr_ff[18:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == gsppm_pkg::STEP_W'(gsppm_pkg::FRAC_BITS - 1)) begin
               st_in = gsppm_pkg::ST_FIN;
            end
         end
         gsppm_pkg::ST_FIN: begin
            ppm_in = fin_sh[61:30];
            st_in  = gsppm_pkg::ST_DONE;
         end
         gsppm_pkg::ST_DONE: begin
            // Wait here only while the previous result is still held.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = (cmd_ff == gsppm_pkg::CMD_CAL) ? gsppm_pkg::KIND_CAL
                                                             : gsppm_pkg::KIND_PPM;
               rsp_ppm_in   = ppm_ff;
               rsp_rs_in    = rs_ff;
               rsp_base_in  = r0_ff;
               rsp_inv_in   = inv_ff;
               st_in        = gsppm_pkg::ST_IDLE;
            end
         end
         default: st_in = gsppm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= gsppm_pkg::ST_IDLE;
         dv_sel_ff    <= gsppm_pkg::DV_AVG;
         fs_ff        <= gsppm_pkg::FULL_SCALE_RST;
         gain_ff      <= gsppm_pkg::GAIN_RST;
         rl_ff        <= gsppm_pkg::LOAD_RES_RST;
         r0_ff        <= gsppm_pkg::BASELINE_RST;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         dv_sel_ff    <= dv_sel_in;
         fs_ff        <= fs_in;
         gain_ff      <= gain_in;
         rl_ff        <= rl_in;
         r0_ff        <= r0_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      adc_ff      <= adc_in;
      n_ff        <= n_in;
      rs_ff       <= rs_in;
      ppm_ff      <= ppm_in;
      inv_ff      <= inv_in;
      dv_num_ff   <= dv_num_in;
      dv_den_ff   <= dv_den_in;
      dv_rem_ff   <= dv_rem_in;
      dv_q_ff     <= dv_q_in;
      dv_ovf_ff   <= dv_ovf_in;
      step_ff     <= step_in;
      lg_m_ff     <= lg_m_in;
      lg_p_ff     <= lg_p_in;
      lg_r_ff     <= lg_r_in;
      lg_sel_ff   <= lg_sel_in;
      lr0_ff      <= lr0_in;
      zp_ff       <= zp_in;
      ip_ff       <= ip_in;
      fr_ff       <= fr_in;
      em_ff       <= em_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ppm_ff  <= rsp_ppm_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_base_ff <= rsp_base_in;
      rsp_inv_ff  <= rsp_inv_in;
   end

   assign req_stall             = st_ff != gsppm_pkg::ST_IDLE;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_gas_ppm           = rsp_ppm_ff;
   assign rsp_sensor_resistance = rsp_rs_ff;
   assign rsp_baseline_value    = rsp_base_ff;
   assign rsp_reading_invalid   = rsp_inv_ff;

endmodule

[src/gsppm_checker.sv]
// Port-level checks of the gas sensor converter and their binding.
`timescale 1ns / 1ps
`include "gas_sensor_adc_to_ppm_top_macros.svh"

module gsppm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_command,
   input logic [11:0] req_adc_sample,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [31:0] rsp_gas_ppm,
   input logic [31:0] rsp_sensor_resistance,
   input logic [31:0] rsp_baseline_value,
   input logic        rsp_reading_invalid,
   input logic        csr_write,
   input logic [1:0]  csr_index,
   input logic [31:0] csr_wdata
);

   `GSPPM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gas_ppm) && $stable(rsp_sensor_resistance), "result beat changed while stalled")
   `GSPPM_ASSERT(a_one_in_work, clock, reset, req_valid && !req_stall |=> req_stall, "second beat taken while one is in work")
   `GSPPM_ASSERT(a_invalid_zero, clock, reset, rsp_valid && rsp_reading_invalid |-> rsp_gas_ppm == 32'h0, "flagged reading carries a nonzero ppm")
   `GSPPM_ASSERT(a_cal_result, clock, reset, rsp_valid && rsp_result_kind == gsppm_pkg::KIND_CAL |-> rsp_gas_ppm == 32'h0 && !rsp_reading_invalid, "calibration beat carries a reading")
   `GSPPM_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind gas_sensor_adc_to_ppm_top gsppm_checker u_gsppm_checker (.*);

[tb/gsppm_scoreboard.sv]
// Scoreboard class that predicts and checks the results of the gas sensor converter.
`timescale 1ns / 1ps

class gsppm_scoreboard;

   typedef struct {
      logic        kind;
      logic [31:0] ppm;
      logic [31:0] rs;
      logic [31:0] r0;
      logic        invalid;
   } reading_type;

   logic [15:0] full_scale;
   logic [15:0] gain;
   logic [31:0] load_res;
   logic [31:0] baseline;
   logic [31:0] cal_sum;
   int          cal_count;
   int          cal_len;
   reading_type pending[$];
   int          mismatches;

   function new(int cal_samples);
      cal_len = cal_samples;
      full_scale = 16'd4095;
      gain = 16'd256;
      load_res = 32'd655360;
      baseline = 32'd65536;
      cal_sum = 0;
      cal_count = 0;
      mismatches = 0;
   endfunction

   function void set_register(logic [1:0] idx, logic [31:0] value);
      if (idx == gsppm_pkg::CSR_FULL_SCALE) begin
         full_scale = value[15:0];
      end else if (idx == gsppm_pkg::CSR_GAIN) begin
         gain = value[15:0];
      end else if (idx == gsppm_pkg::CSR_LOAD_RES) begin
         load_res = value;
      end
   endfunction

   // Returns 0 when the resistance is zero (divider at or beyond full scale).
   function bit sensor_res(logic [31:0] adc, output logic [31:0] rs);
      logic [63:0] num;
      logic [63:0] den;
      logic [127:0] q;
      num = 64'(adc) * gain;
      den = 64'(full_scale) << 8;
      if (adc == 0) begin
         rs = 32'hFFFF_FFFF;
         return 1;
      end
      if (num >= den) begin
         rs = 0;
         return 0;
      end
      q = (128'(load_res) * (den - num)) / num;
      rs = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      return rs != 0;
   endfunction

   function longint log2_fixed(logic [31:0] v);
      int pos;
      logic [63:0] m;
      longint r;
      pos = 31;
      while (pos > 0 && v[pos] == 1'b0) pos--;
      m = 64'(v) << (31 - pos);
      r = pos;
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 31;
         r = r * 2;
         if (m >= 64'h1_0000_0000) begin
            r += 1;
            m >>= 1;
         end
      end
      return r;
   endfunction

   function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function logic [31:0] concentration(logic [31:0] rs, logic [31:0] r0);
      longint diff;
      longint prod;
      longint scaled;
      longint z;
      logic [63:0] m;
      logic [63:0] t;
      logic [19:0] frac;
      int ip;
      diff = log2_fixed(r0) - log2_fixed(rs);
      prod = diff * 64'sd1361787;
      // Floor division by 2^20, rounding toward minus infinity.
      scaled = prod >>> 20;
      z = 64'sd7690390 + scaled + (64'sd10 << 20);
      if (z < 0) return 0;
      if (z >= (64'sd32 << 20)) return 32'hFFFF_FFFF;
      ip = int'(z >>> 20);
      frac = z[19:0];
      m = 64'd1 << 30;
      t = int_sqrt(64'd1 << 61);
      for (int k = 1; k <= 20; k++) begin
         if (frac[20 - k]) m = (m * t) >> 30;
         t = int_sqrt(t << 30);
      end
      return 32'((m << ip) >> 30);
   endfunction

   function void note_beat(logic cmd, logic [11:0] adc);
      reading_type e;
      logic [31:0] rs;
      bit ok;
      if (cmd == gsppm_pkg::CMD_MEASURE) begin
         ok = sensor_res(32'(adc), rs);
         e.kind = gsppm_pkg::KIND_PPM;
         e.rs = rs;
         e.r0 = baseline;
         if (!ok || adc == 0 || baseline == 0) begin
            e.ppm = 0;
            e.invalid = 1;
         end else begin
            e.ppm = concentration(rs, baseline);
            e.invalid = 0;
         end
         pending.push_back(e);
         return;
      end
      cal_sum += adc;
      cal_count++;
      if (cal_count < cal_len) return;
      void'(sensor_res(cal_sum / cal_len, rs));
      baseline = 32'((64'(rs) * 2) / 3);
      cal_sum = 0;
      cal_count = 0;
      e.kind = gsppm_pkg::KIND_CAL;
      e.ppm = 0;
      e.rs = rs;
      e.r0 = baseline;
      e.invalid = 0;
      pending.push_back(e);
   endfunction

   function void check_result(logic kind, logic [31:0] ppm, logic [31:0] rs,
                              logic [31:0] r0, logic invalid);
      reading_type e;
      reading_type got;
      got.kind = kind;
      got.ppm = ppm;
      got.rs = rs;
      got.r0 = r0;
      got.invalid = invalid;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result beat: kind %0d", got.kind);
         return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind || got.ppm !== e.ppm || got.rs !== e.rs ||
          got.r0 !== e.r0 || got.invalid !== e.invalid) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch: expected kind %0d ppm %h rs %h r0 %h inv %0d",
                     e.kind, e.ppm, e.rs, e.r0, e.invalid);
            $display("          actual   kind %0d ppm %h rs %h r0 %h inv %0d",
                     got.kind, got.ppm, got.rs, got.r0, got.invalid);
         end
      end
   endfunction

endclass

[tb/testbench.sv]
// Top-level testbench of the gas sensor ADC-to-ppm converter.
`timescale 1ns / 1ps

module testbench;

   // Calibration run length of the block as built.
   localparam int CAL_LEN = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [11:0] req_adc_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic [31:0] rsp_gas_ppm;
   logic [31:0] rsp_sensor_resistance;
   logic [31:0] rsp_baseline_value;
   logic        rsp_reading_invalid;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   gsppm_scoreboard ppm_book;
   bit hold_off;     // when set, the receiver stalls for a long stretch
   bit rsp_free;     // when set, the receiver never stalls

   gas_sensor_adc_to_ppm_top #(.ADC_BITS(12), .CAL_SAMPLES(CAL_LEN)) dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Safety limit that ends a run that hangs and reports it as failed.
   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Half of the gaps are absent, most of the rest are short and a few are long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // Offers one beat and holds it until the block takes it; valid stays high afterwards.
   task automatic send_beat(logic cmd, logic [11:0] adc);
      req_valid <= 1;
      req_command <= cmd;
      req_adc_sample <= adc;
      do @(posedge clock); while (req_stall);
      ppm_book.note_beat(cmd, adc);
      @(negedge clock);
   endtask

   task automatic send_random(int gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      // About one beat in three is a calibration beat.
      send_beat(($urandom_range(0, 2) == 0) ? gsppm_pkg::CMD_CAL : gsppm_pkg::CMD_MEASURE,
                12'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (ppm_book.pending.size() != 0) @(negedge clock);
      // A calibration beat that ends no run may still be in work.
      repeat (10) @(negedge clock);
   endtask

   // Drives one register write; the caller drops the write enable afterwards.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      ppm_book.set_register(idx, value);
   endtask

   // Receiver: takes result beats whenever its stall is low at a rising edge.
   initial begin
      rsp_stall = 1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (2000) @(negedge clock);
            hold_off = 0;
         end else if (!rsp_free && $urandom_range(0, 40) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(50, 400)) @(negedge clock);
         end
         rsp_stall <= rsp_free ? 1'b0 : ($urandom_range(0, 3) == 0 ? 1'b1 : 1'b0);
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            ppm_book.check_result(rsp_result_kind, rsp_gas_ppm, rsp_sensor_resistance,
                                  rsp_baseline_value, rsp_reading_invalid);
         end
         @(negedge clock);
      end
   end

   initial begin
      int wait_cycles;
      ppm_book = new(CAL_LEN);
      reset = 1;
      req_valid = 0;
      req_command = gsppm_pkg::CMD_MEASURE;
      req_adc_sample = 0;
      csr_write = 0;
      csr_index = gsppm_pkg::CSR_FULL_SCALE;
      csr_wdata = 0;
      hold_off = 0;
      rsp_free = 1;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part: zero, full scale, lowest and top bit, alternating bits and calibration.
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd0);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd4095);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd1);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd2048);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd2730);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd1365);
      // A calibration run with zero samples drives the baseline to its maximum.
      repeat (CAL_LEN) send_beat(gsppm_pkg::CMD_CAL, 12'd0);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd1);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd4000);
      // A run at full scale sets the baseline to zero, which flags the readings.
      repeat (CAL_LEN) send_beat(gsppm_pkg::CMD_CAL, 12'd4095);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd100);
      // A mid-scale run brings back a usable baseline.
      repeat (CAL_LEN) send_beat(gsppm_pkg::CMD_CAL, 12'd2000);
      send_beat(gsppm_pkg::CMD_MEASURE, 12'd1500);
      wait_drained();
      rsp_free = 0;

      // Random part across several register settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(gsppm_pkg::CSR_FULL_SCALE, 32'd1);
               write_reg(gsppm_pkg::CSR_GAIN, 32'd1);
               write_reg(gsppm_pkg::CSR_LOAD_RES, 32'd1);
            end
            1: begin
               write_reg(gsppm_pkg::CSR_FULL_SCALE, 32'd65535);
               write_reg(gsppm_pkg::CSR_GAIN, 32'd65535);
               write_reg(gsppm_pkg::CSR_LOAD_RES, 32'hFFFF_FFFF);
            end
            2: begin
               write_reg(gsppm_pkg::CSR_FULL_SCALE, 32'd65535);
               write_reg(gsppm_pkg::CSR_GAIN, 32'd1);
               write_reg(gsppm_pkg::CSR_LOAD_RES, 32'h0001_0000);
            end
            3: begin
               write_reg(gsppm_pkg::CSR_FULL_SCALE, 32'd4095);
               write_reg(gsppm_pkg::CSR_GAIN, 32'd256);
               write_reg(gsppm_pkg::CSR_LOAD_RES, 32'd655360);
            end
            default: begin
               write_reg(gsppm_pkg::CSR_FULL_SCALE, 32'($urandom_range(1, 65535)));
               write_reg(gsppm_pkg::CSR_GAIN, 32'($urandom_range(1, 65535)));
               write_reg(gsppm_pkg::CSR_LOAD_RES, $urandom);
            end
         endcase
         csr_write <= 0;
         // Phase 1 lets the receiver hold off while the sender keeps offering.
         if (phase == 1) hold_off = 1;
         for (int i = 0; i < 35; i++) begin
            send_random(phase != 1);
         end
         // Every phase ends with the sender paused until all results are in.
         wait_drained();
      end

      wait_cycles = 0;
      while (ppm_book.pending.size() != 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (300) @(negedge clock);
      if (ppm_book.mismatches == 0 && ppm_book.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/gsppm_pkg.sv
src/gas_sensor_adc_to_ppm_top.sv
src/gsppm_checker.sv
tb/gsppm_scoreboard.sv
tb/testbench.sv
